// ===== design/ffbra_pkg.sv =====
// ----------------------------------------------------------------------------
// ffbra_pkg
// Shared types and constants of the first-fit bitmap range allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package ffbra_pkg;

   localparam int MODE_W    = 2;
   localparam int CNT_W     = 11;
   localparam int START_W   = 10;
   localparam int STEP_W    = 16;
   localparam int ADDR_W    = 64;
   localparam int STAT_W    = 3;
   localparam int SLOT_W    = 12;   // slot position plus headroom
   localparam int WORD_BITS = 32;   // bitmap word width
   localparam int CSR_IDX_W = 3;

   localparam logic [MODE_W-1:0] MODE_RESERVE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LOOKUP  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SLOTS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CPU     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GPU     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VISIBLE = 3'd4;

   typedef enum logic [STAT_W-1:0] {
      ST_OK           = 3'd0,
      ST_NO_SPACE     = 3'd1,
      ST_OUT_OF_RANGE = 3'd2,
      ST_NOT_VISIBLE  = 3'd3,
      ST_ALREADY_FREE = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_GRP,
      S_MARK_RD,
      S_MARK_WR,
      S_LOOK1,
      S_LOOK2
   } state_type;

   typedef struct packed {
      logic               valid;
      status_type         status;
      logic [START_W-1:0] start;
      logic [CNT_W-1:0]   count;
      logic               cpu_en;
      logic               gpu_en;
   } rsp_type;

endpackage
`default_nettype wire

// ===== design/ffbra_bitmap_ram.sv =====
// ----------------------------------------------------------------------------
// ffbra_bitmap_ram
// Occupancy bitmap memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module ffbra_bitmap_ram #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  wire logic                           clock,
   input  wire logic                           we,
   input  wire logic [AW-1:0]                  waddr,
   input  wire logic [ffbra_pkg::WORD_BITS-1:0] wdata,
   input  wire logic                           re,
   input  wire logic [AW-1:0]                  raddr,
   output      logic [ffbra_pkg::WORD_BITS-1:0] rdata
);
   import ffbra_pkg::*;

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];   // held until the next read
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== design/ffbra_handle.sv =====
// ----------------------------------------------------------------------------
// ffbra_handle
// Handle generator: slot times step, then added to both base addresses.
// ----------------------------------------------------------------------------
`default_nettype none
module ffbra_handle (
   input  wire logic                          clock,
   input  wire logic [ffbra_pkg::CNT_W-1:0]   slot,
   input  wire logic [ffbra_pkg::STEP_W-1:0]  step,
   input  wire logic [ffbra_pkg::ADDR_W-1:0]  cpu_base,
   input  wire logic [ffbra_pkg::ADDR_W-1:0]  gpu_base,
   output      logic [ffbra_pkg::ADDR_W-1:0]  cpu_sum,
   output      logic [ffbra_pkg::ADDR_W-1:0]  gpu_sum
);
   import ffbra_pkg::*;

   logic [CNT_W+STEP_W-1:0] delta_ff, delta_in;
   logic [ADDR_W-1:0]       cpu_ff, cpu_in, gpu_ff, gpu_in;

   always_comb begin
      delta_in = (CNT_W+STEP_W)'(slot) * (CNT_W+STEP_W)'(step);
      cpu_in   = cpu_base + ADDR_W'(delta_ff);
      gpu_in   = gpu_base + ADDR_W'(delta_ff);
   end

   always_ff @(posedge clock) begin
      delta_ff <= delta_in;
      cpu_ff   <= cpu_in;
      gpu_ff   <= gpu_in;
   end

   assign cpu_sum = cpu_ff;
   assign gpu_sum = gpu_ff;

endmodule
`default_nettype wire

// ===== design/ffbra_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffbra_ctrl
// Sequencer: clearing pass, first-fit scan, range mark/release, lookup timing.
// ----------------------------------------------------------------------------
`default_nettype none
module ffbra_ctrl #(
   parameter int WORDS = 32,
   parameter int AW    = 5
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output      logic                           busy,
   input  wire logic [ffbra_pkg::MODE_W-1:0]   mode,
   input  wire logic [ffbra_pkg::CNT_W-1:0]    offset,
   input  wire logic [ffbra_pkg::CNT_W-1:0]    count,
   input  wire logic [ffbra_pkg::CNT_W-1:0]    cap,
   input  wire logic                           visible,
   output      logic [ffbra_pkg::CNT_W-1:0]    look_slot,
   output      logic                           mem_we,
   output      logic [AW-1:0]                  mem_waddr,
   output      logic [ffbra_pkg::WORD_BITS-1:0] mem_wdata,
   output      logic                           mem_re,
   output      logic [AW-1:0]                  mem_raddr,
   input  wire logic [ffbra_pkg::WORD_BITS-1:0] mem_rdata,
   output      ffbra_pkg::rsp_type             rsp
);
   import ffbra_pkg::*;

   state_type            state_ff, state_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic [MODE_W-1:0]    mode_ff, mode_in;
   logic [CNT_W-1:0]     off_ff, off_in, cnt_ff, cnt_in, run_ff, run_in;
   logic [SLOT_W-1:0]    pos_ff, pos_in, cur_ff, cur_in, end_ff, end_in, strt_ff, strt_in;
   logic                 flag_ff, flag_in;
   rsp_type              rsp_ff, rsp_in;

   logic [CNT_W-1:0]     run;
   logic                 fnd, same;
   logic [SLOT_W-1:0]    endp, s;
   logic [4:0]           lo, hi;
   logic [WORD_BITS-1:0] mask;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         rsp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         rsp_ff   <= rsp_in;
      end
      mode_ff <= mode_in;
      off_ff  <= off_in;
      cnt_ff  <= cnt_in;
      run_ff  <= run_in;
      pos_ff  <= pos_in;
      cur_ff  <= cur_in;
      end_ff  <= end_in;
      strt_ff <= strt_in;
      flag_ff <= flag_in;
   end

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      mode_in   = mode_ff;
      off_in    = off_ff;
      cnt_in    = cnt_ff;
      run_in    = run_ff;
      pos_in    = pos_ff;
      cur_in    = cur_ff;
      end_in    = end_ff;
      strt_in   = strt_ff;
      flag_in   = flag_ff;
      rsp_in    = '0;
      mem_we    = 1'b0;
      mem_waddr = AW'(cur_ff >> 5);
      mem_wdata = '0;
      mem_re    = 1'b0;
      mem_raddr = AW'(cur_ff >> 5);

      // eight-slot step of the run search
      run  = run_ff;
      fnd  = 1'b0;
      endp = '0;
      for (int k = 0; k < 8; k++) begin
         s = pos_ff + SLOT_W'(k);
         if (!fnd && s < SLOT_W'(cap)) begin
            run = mem_rdata[{pos_ff[4:3], 3'(k)}] ? '0 : run + 1'b1;
            if (run == cnt_ff) begin
               fnd  = 1'b1;
               endp = s;
            end
         end
      end

      // bit mask of the current word within [cur, end]
      same = (cur_ff[SLOT_W-1:5] == end_ff[SLOT_W-1:5]);
      lo   = cur_ff[4:0];
      hi   = same ? end_ff[4:0] : 5'd31;
      for (int b = 0; b < WORD_BITS; b++) begin
         mask[b] = (5'(b) >= lo) && (5'(b) <= hi);
      end

      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               mode_in = mode;
               off_in  = offset;
               cnt_in  = count;
               flag_in = 1'b0;
               rsp_in.status = ST_OK;
               priority if (mode == MODE_RESERVE) begin
                  if (count == '0) begin
                     rsp_in.valid = 1'b1;
                  end else if (count > cap) begin
                     rsp_in.valid  = 1'b1;
                     rsp_in.status = ST_NO_SPACE;
                  end else begin
                     pos_in   = '0;
                     run_in   = '0;
                     state_in = S_SCAN_RD;
                  end
               end else if (mode == MODE_RELEASE) begin
                  if (count == '0) begin
                     rsp_in.valid = 1'b1;
                  end else if (offset > cap || count > cap - offset) begin
                     rsp_in.valid  = 1'b1;
                     rsp_in.status = ST_OUT_OF_RANGE;
                  end else begin
                     cur_in   = SLOT_W'(offset);
                     end_in   = SLOT_W'(offset) + SLOT_W'(count) - 1'b1;
                     state_in = S_MARK_RD;
                  end
               end else if (mode == MODE_LOOKUP) begin
                  if (offset >= cap) begin
                     rsp_in.valid  = 1'b1;
                     rsp_in.status = ST_OUT_OF_RANGE;
                  end else begin
                     state_in = S_LOOK1;
                  end
               end else begin
                  rsp_in.valid  = 1'b1;
                  rsp_in.status = ST_OUT_OF_RANGE;
               end
            end
         end
         S_SCAN_RD: begin
            mem_re    = 1'b1;
            mem_raddr = AW'(pos_ff >> 5);
            state_in  = S_SCAN_GRP;
         end
         S_SCAN_GRP: begin
            run_in = run;
            if (fnd) begin
               strt_in  = endp + 1'b1 - SLOT_W'(cnt_ff);
               cur_in   = endp + 1'b1 - SLOT_W'(cnt_ff);
               end_in   = endp;
               state_in = S_MARK_RD;
            end else if (pos_ff + SLOT_W'(8) >= SLOT_W'(cap)) begin
               rsp_in.valid  = 1'b1;
               rsp_in.status = ST_NO_SPACE;
               state_in      = S_IDLE;
            end else begin
               pos_in = pos_ff + SLOT_W'(8);
               if (pos_ff[4:3] == 2'd3) begin
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_MARK_RD: begin
            mem_re   = 1'b1;
            state_in = S_MARK_WR;
         end
         S_MARK_WR: begin
            mem_we = 1'b1;
            if (mode_ff == MODE_RELEASE) begin
               mem_wdata = mem_rdata & ~mask;
               flag_in   = flag_ff | ((mem_rdata & mask) != mask);
            end else begin
               mem_wdata = mem_rdata | mask;
            end
            if (same) begin
               rsp_in.valid = 1'b1;
               state_in     = S_IDLE;
               if (mode_ff == MODE_RELEASE) begin
                  rsp_in.status = flag_in ? ST_ALREADY_FREE : ST_OK;
               end else begin
                  rsp_in.status = ST_OK;
                  rsp_in.start  = START_W'(strt_ff);
                  rsp_in.count  = cnt_ff;
               end
            end else begin
               cur_in   = {cur_ff[SLOT_W-1:5] + 1'b1, 5'd0};
               state_in = S_MARK_RD;
            end
         end
         S_LOOK1: begin
            state_in = S_LOOK2;
         end
         S_LOOK2: begin
            rsp_in.valid  = 1'b1;
            rsp_in.status = visible ? ST_OK : ST_NOT_VISIBLE;
            rsp_in.cpu_en = 1'b1;
            rsp_in.gpu_en = visible;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != S_IDLE);
   assign look_slot = off_ff;
   assign rsp       = rsp_ff;

endmodule
`default_nettype wire

// ===== design/first_fit_bitmap_range_allocator_top.sv =====
// ----------------------------------------------------------------------------
// first_fit_bitmap_range_allocator_top
// First-fit contiguous slot allocator over a word-wide occupancy bitmap.
// ----------------------------------------------------------------------------
// Channel | Ports                                   | Transfer
// req     | start, busy, req_mode/offset/count      | start && !busy
// rsp     | rsp_strobe, rsp_status ... gpu_handle   | one cycle, no backpressure
// csr     | csr_valid, csr_ready, csr_index/wdata   | csr_valid && csr_ready
//
// Reserve scans the bitmap eight slots a cycle, pausing for a read of each
// 32-bit word, then reads and writes back each word that it marks. Release
// reads and writes back each word touched; lookup registers a multiply, then
// an add; immediate cases answer from idle. The single bitmap memory sets the pace.
// Reset: a clearing pass writes every bitmap word, busy high.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module first_fit_bitmap_range_allocator_top #(
   parameter int MAX_SLOTS = 1024
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output      logic                            busy,
   input  wire logic [ffbra_pkg::MODE_W-1:0]    req_mode,
   input  wire logic [ffbra_pkg::CNT_W-1:0]     req_request_offset,
   input  wire logic [ffbra_pkg::CNT_W-1:0]     req_request_count,
   output      logic                            rsp_strobe,
   output      logic [ffbra_pkg::STAT_W-1:0]    rsp_status,
   output      logic [ffbra_pkg::START_W-1:0]   rsp_range_start,
   output      logic [ffbra_pkg::CNT_W-1:0]     rsp_range_count,
   output      logic [ffbra_pkg::ADDR_W-1:0]    rsp_cpu_handle,
   output      logic [ffbra_pkg::ADDR_W-1:0]    rsp_gpu_handle,
   input  wire logic                            csr_valid,
   output      logic                            csr_ready,
   input  wire logic [ffbra_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [ffbra_pkg::ADDR_W-1:0]    csr_wdata
);
   import ffbra_pkg::*;

   localparam int WORDS = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   // largest capacity reachable through the 11-bit slot count
   localparam logic [CNT_W-1:0] MAX_CAP =
      (MAX_SLOTS > 2047) ? CNT_W'(2047) : CNT_W'(MAX_SLOTS);

   // configuration transactions
   logic [CNT_W-1:0]  slots_ff;
   logic [STEP_W-1:0] step_ff;
   logic [ADDR_W-1:0] cpu_base_ff, gpu_base_ff;
   logic              vis_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff    <= CNT_W'(1024);
         step_ff     <= STEP_W'(32);
         cpu_base_ff <= '0;
         gpu_base_ff <= '0;
         vis_ff      <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SLOTS:   slots_ff    <= csr_wdata[CNT_W-1:0];
            CSR_STEP:    step_ff     <= csr_wdata[STEP_W-1:0];
            CSR_CPU:     cpu_base_ff <= csr_wdata;
            CSR_GPU:     gpu_base_ff <= csr_wdata;
            CSR_VISIBLE: vis_ff      <= csr_wdata[0];
            default: ;   // unmapped index, dropped
         endcase
      end
   end

   assign csr_ready = 1'b1;

   logic [CNT_W-1:0] cap;
   assign cap = (slots_ff > MAX_CAP) ? MAX_CAP : slots_ff;

   logic                 mem_we, mem_re;
   logic [AW-1:0]        mem_waddr, mem_raddr;
   logic [WORD_BITS-1:0] mem_wdata, mem_rdata;
   logic [CNT_W-1:0]     look_slot;
   logic [ADDR_W-1:0]    cpu_sum, gpu_sum;
   rsp_type              rsp;

   ffbra_bitmap_ram #(.DEPTH(WORDS), .AW(AW)) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   ffbra_handle u_handle (
      .clock    (clock),
      .slot     (look_slot),
      .step     (step_ff),
      .cpu_base (cpu_base_ff),
      .gpu_base (gpu_base_ff),
      .cpu_sum  (cpu_sum),
      .gpu_sum  (gpu_sum)
   );

   ffbra_ctrl #(.WORDS(WORDS), .AW(AW)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .mode      (req_mode),
      .offset    (req_request_offset),
      .count     (req_request_count),
      .cap       (cap),
      .visible   (vis_ff),
      .look_slot (look_slot),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata),
      .rsp       (rsp)
   );

   // result transaction; CPU handle in an in-range lookup, GPU handle only when visible
   assign rsp_strobe      = rsp.valid;
   assign rsp_status      = rsp.status;
   assign rsp_range_start = rsp.start;
   assign rsp_range_count = rsp.count;
   assign rsp_cpu_handle  = rsp.cpu_en ? cpu_sum : '0;
   assign rsp_gpu_handle  = rsp.gpu_en ? gpu_sum : '0;

   // an accepted request either responds next cycle or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted request neither answered nor in progress");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_status <= ST_ALREADY_FREE))
      else $error("result status outside the defined codes");

   a_fail_no_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ST_OK) |-> (rsp_range_count == '0))
      else $error("failed request reports a reserved range");

   a_range_in_heap: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_range_count != '0) |->
      ((SLOT_W'(rsp_range_start) + SLOT_W'(rsp_range_count)) <= SLOT_W'(cap)))
      else $error("reserved range extends past the heap");

endmodule
`default_nettype wire
